### sv/ipd_pkg.sv
`timescale 1ns / 1ps

package ipd_pkg;

   // Sizing of the line tracker and of the length accumulator.
   localparam int LINE_CAPACITY = 64;
   localparam int LENGTH_BITS   = 16;
   localparam int LC_BITS       = $clog2(LINE_CAPACITY);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   // Characters of interest on the link.
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // "OK" with the first character in the low byte.
   localparam logic [15:0] HEAD_OK = 16'h4B4F;

   // Length of the "+IPD," prefix.
   localparam logic [2:0] PREFIX_LEN = 3'd5;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_LEN  = 2'd1,
      MODE_DATA = 2'd2
   } mode_type;

   // One result item.
   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        payload_last;
      logic        link_ready;
      logic [15:0] frame_length;
   } result_type;

   // Character expected at a given position of "+IPD,".
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h2B;
         3'd1:    c = 8'h49;
         3'd2:    c = 8'h50;
         3'd3:    c = 8'h44;
         3'd4:    c = 8'h2C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### sv/ipd_frame_extractor_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_rx_byte[7:0]
// rsp       out        rsp_valid / rsp_ready  payload_valid, payload_byte[7:0],
//                                             payload_last, link_ready,
//                                             frame_length[15:0]
//
// Every item gives exactly one result item, which is registered in the input
// register and then in the result register before it appears on rsp; one item
// per cycle is sustained when the output is not stalled. The parser steps once
// per item in a single pass between the input register and the result register.
// Reset is synchronous and active high; it clears the parser and both stages.
// A stalled result holds in the output register while the input register
// still takes one further item.

module ipd_frame_extractor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_last,
   output logic        rsp_link_ready,
   output logic [15:0] rsp_frame_length
);
   import ipd_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       space;
   logic       step;
   result_type result;
   result_type rsp_data;

   // An item moves on when the result register has room for it.
   assign step = byte_valid && space;

   ipd_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .step        (step),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   ipd_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (byte_data),
      .result  (result)
   );

   ipd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .result    (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_payload_valid = rsp_data.payload_valid;
   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_payload_last  = rsp_data.payload_last;
   assign rsp_link_ready    = rsp_data.link_ready;
   assign rsp_frame_length  = rsp_data.frame_length;

endmodule

### sv/ipd_in_stage.sv
`timescale 1ns / 1ps

module ipd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       step,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   import ipd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;

   // The register frees up whenever its item moves on in the same cycle.
   assign req_ready = !valid_ff || step;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The byte itself needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

### sv/ipd_parse_core.sv
`timescale 1ns / 1ps

module ipd_parse_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   output ipd_pkg::result_type result
);
   import ipd_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [2:0]             prog_ff, prog_in;
   logic                   past_id_ff, past_id_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [LENGTH_BITS-1:0] fwd_ff, fwd_in;
   logic                   ready_ff, ready_in;
   logic [LC_BITS-1:0]     count_ff, count_in;
   logic [15:0]            head_ff, head_in;

   // Next state of the parser for the byte in the input register.
   always_comb begin
      logic [LENGTH_BITS+3:0] prod;
      logic [LENGTH_BITS-1:0] fwd_inc;
      logic [LENGTH_BITS-1:0] flen;
      logic [2:0]             prog_nx;
      logic                   valid;
      logic                   last;

      mode_in    = mode_ff;
      prog_in    = prog_ff;
      past_id_in = past_id_ff;
      len_in     = len_ff;
      fwd_in     = fwd_ff;
      ready_in   = ready_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      valid      = 1'b0;
      last       = 1'b0;
      flen       = len_ff;
      fwd_inc    = fwd_ff + LENGTH_BITS'(1);
      prod       = ((LENGTH_BITS+4)'(len_ff) << 3) + ((LENGTH_BITS+4)'(len_ff) << 1)
                   + (LENGTH_BITS+4)'(4'(rx_byte - CHAR_ZERO));
      prog_nx    = prog_ff;

      case (mode_ff)
         MODE_LEN: begin
            if (!past_id_ff) begin
               if (rx_byte == CHAR_COMMA) begin
                  past_id_in = 1'b1;
               end
            end else if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
               // Saturate rather than wrap on an absurd length.
               len_in = (prod > (LENGTH_BITS+4)'(LEN_MAX)) ? LEN_MAX
                                                           : prod[LENGTH_BITS-1:0];
            end else if (rx_byte == CHAR_COLON) begin
               fwd_in  = '0;
               mode_in = (len_ff != '0) ? MODE_DATA : MODE_IDLE;
            end
            flen = len_in;
         end
         MODE_DATA: begin
            // Forward the byte and close the frame on its final byte.
            if (fwd_ff < len_ff) begin
               valid  = 1'b1;
               fwd_in = fwd_inc;
            end
            if (fwd_in >= len_ff) begin
               last    = valid;
               mode_in = MODE_IDLE;
               len_in  = '0;
            end
            flen = len_ff;
         end
         default: begin
            mode_in = MODE_IDLE;

            // Line tracker: an "OK" line sets the sticky ready flag.
            if (rx_byte == CHAR_LF || rx_byte == CHAR_CR) begin
               if (count_ff >= LC_BITS'(2) && head_ff == HEAD_OK) begin
                  ready_in = 1'b1;
               end
               count_in = '0;
            end else if (count_ff < LC_BITS'(LINE_CAPACITY - 1)) begin
               if (count_ff == '0) begin
                  head_in[7:0] = rx_byte;
               end else if (count_ff == LC_BITS'(1)) begin
                  head_in[15:8] = rx_byte;
               end
               count_in = count_ff + LC_BITS'(1);
            end

            // Prefix matcher, restarting on a plus sign.
            if (prog_ff == 3'd0) begin
               if (rx_byte == CHAR_PLUS) begin
                  prog_nx = 3'd1;
               end
            end else if (prog_ff < PREFIX_LEN && rx_byte == prefix_char(prog_ff)) begin
               prog_nx = prog_ff + 3'd1;
            end else begin
               prog_nx = (rx_byte == CHAR_PLUS) ? 3'd1 : 3'd0;
            end
            prog_in = prog_nx;
            if (prog_nx == PREFIX_LEN) begin
               mode_in    = MODE_LEN;
               prog_in    = 3'd0;
               past_id_in = 1'b0;
               len_in     = '0;
            end
            flen = len_in;
         end
      endcase

      result.payload_valid = valid;
      result.payload_byte  = valid ? rx_byte : 8'h00;
      result.payload_last  = last;
      result.link_ready    = ready_in;
      result.frame_length  = 16'(flen);
   end

   // Parser state advances once for each item processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         prog_ff    <= 3'd0;
         past_id_ff <= 1'b0;
         len_ff     <= '0;
         fwd_ff     <= '0;
         ready_ff   <= 1'b0;
         count_ff   <= '0;
      end else if (step) begin
         mode_ff    <= mode_in;
         prog_ff    <= prog_in;
         past_id_ff <= past_id_in;
         len_ff     <= len_in;
         fwd_ff     <= fwd_in;
         ready_ff   <= ready_in;
         count_ff   <= count_in;
      end
   end

   // The line head is written before it is ever read, so it has no reset.
   always_ff @(posedge clock) begin
      if (step) begin
         head_ff <= head_in;
      end
   end

   // A frame in progress always has a length still to run.
   a_data_len : assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DATA |-> len_ff != '0)
      else $error("payload mode with zero announced length");

   // The link-ready flag never clears once set.
   a_ready_sticky : assert property (@(posedge clock) disable iff (reset)
      ready_ff |=> ready_ff)
      else $error("link-ready flag dropped");

   // The final byte of a frame hands the parser back to idle.
   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      step && result.payload_last |=> mode_ff == MODE_IDLE)
      else $error("parser not idle after final payload byte");

   // Only a forwarded byte can be marked as final.
   a_last_valid : assert property (@(posedge clock) disable iff (reset)
      step && result.payload_last |-> result.payload_valid && mode_ff == MODE_DATA)
      else $error("final mark on a byte that is not payload");

endmodule

### sv/ipd_out_stage.sv
`timescale 1ns / 1ps

module ipd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  ipd_pkg::result_type result,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ipd_pkg::result_type rsp_data
);
   import ipd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // Room for a new item when empty or when the held one is taken now.
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = step || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
